### src/bkl_pkg.sv
// ----------------------------------------------------------------------------
// bkl_pkg
// Shared constants and types of the block keyword lexer: limits, token kinds,
// operation codes and the packed keyword spellings.
// ----------------------------------------------------------------------------
`default_nettype none

package bkl_pkg;

	localparam int MAX_LINES   = 65536;
	localparam int MAX_COLUMNS = 4096;

	localparam logic [15:0] LINE_CAP = (MAX_LINES > 65536) ? 16'hFFFF : 16'(MAX_LINES - 1);
	localparam logic [11:0] COL_CAP  = (MAX_COLUMNS > 4096) ? 12'hFFF : 12'(MAX_COLUMNS - 1);
	localparam logic [11:0] LEN_CAP  = 12'hFFF;

	// Operation codes carried on the input tuser.
	typedef enum logic [1:0] {
		OP_CHAR    = 2'd0,
		OP_EOL     = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		K_IF       = 4'd0,
		K_THEN     = 4'd1,
		K_ELSIF    = 4'd2,
		K_ELSE     = 4'd3,
		K_END_IF   = 4'd4,
		K_FOR      = 4'd5,
		K_WHILE    = 4'd6,
		K_LOOP     = 4'd7,
		K_END_LOOP = 4'd8,
		K_BEGIN    = 4'd9,
		K_END      = 4'd10,
		K_CASE     = 4'd11,
		K_END_CASE = 4'd12
	} kind_t;

	// Keyword spellings, first character in the lowest seven bits.
	localparam logic [34:0] P_IF    = 35'({7'h46, 7'h49});
	localparam logic [34:0] P_THEN  = 35'({7'h4E, 7'h45, 7'h48, 7'h54});
	localparam logic [34:0] P_ELSIF = 35'({7'h46, 7'h49, 7'h53, 7'h4C, 7'h45});
	localparam logic [34:0] P_ELSE  = 35'({7'h45, 7'h53, 7'h4C, 7'h45});
	localparam logic [34:0] P_FOR   = 35'({7'h52, 7'h4F, 7'h46});
	localparam logic [34:0] P_WHILE = 35'({7'h45, 7'h4C, 7'h49, 7'h48, 7'h57});
	localparam logic [34:0] P_LOOP  = 35'({7'h50, 7'h4F, 7'h4F, 7'h4C});
	localparam logic [34:0] P_BEGIN = 35'({7'h4E, 7'h49, 7'h47, 7'h45, 7'h42});
	localparam logic [34:0] P_END   = 35'({7'h44, 7'h4E, 7'h45});
	localparam logic [34:0] P_CASE  = 35'({7'h45, 7'h53, 7'h41, 7'h43});

	localparam logic [15:0] CH_SLASH = 16'h002F;
	localparam logic [15:0] CH_DASH  = 16'h002D;
	localparam logic [15:0] CH_STAR  = 16'h002A;
	localparam logic [15:0] CH_QUOTE = 16'h0027;
	localparam logic [15:0] CH_DOLLAR = 16'h0024;
	localparam logic [15:0] CH_HASH  = 16'h0023;
	localparam logic [15:0] CH_UNDER = 16'h005F;
	localparam logic [15:0] CH_SPACE = 16'h0020;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] line;
		logic [11:0] col;
		logic [11:0] len;
		logic        last;
	} tok_t;

	// Up to two tokens produced while handling one word.
	typedef struct packed {
		logic [1:0] n;
		tok_t       t0;
		tok_t       t1;
	} slots_t;

endpackage

`default_nettype wire

### src/block_keyword_lexer_core.sv
// ----------------------------------------------------------------------------
// block_keyword_lexer_core
// Streaming lexer that finds block keywords in source text, skipping comments
// and quoted strings, and reports kind, line, column and length of each one.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready. s_tuser carries the operation
//   (character, end of line, start new text) and s_tdata the 16-bit code unit,
//   which only matters for a character. Tokens leave on m_tvalid/m_tready;
//   m_tuser holds the token kind, m_tdata the line, column and length, and
//   m_tlast marks the last token caused by one input word.
//   A token is offered once its input word has passed the input register
//   and been written to the output queue. Throughput is one input word per
//   cycle while the queue holds at most one token; an input word that closes
//   END plus another keyword yields two tokens into the three-entry output
//   queue, and the input register then waits while it holds more than one.
//   When the receiver stalls, tokens collect in the output queue; once it is
//   more than one deep the input register holds its word and s_tready falls
//   after that register is full. Nothing is dropped.
//   Reset (arst_n low) empties the input register and the queue and puts the
//   scanner in its start-of-text state; a start-new-text word does the same
//   to the scanner state but leaves queued tokens in place.
// ----------------------------------------------------------------------------
`default_nettype none

module block_keyword_lexer_core import bkl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] code_unit
	input  wire logic [1:0]  s_tuser,   // [1:0] operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [15:0] line_index, [27:16] column, [39:28] token_length
	output logic [3:0]       m_tuser,   // [3:0] token_kind
	output logic             m_tlast
);

	typedef enum logic [2:0] {
		M_NORMAL = 3'd0,
		M_BLOCK  = 3'd1,
		M_LINE   = 3'd2,
		M_STRING = 3'd3,
		M_QUOTE  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		P_NONE  = 2'd0,
		P_SLASH = 2'd1,
		P_DASH  = 2'd2,
		P_STAR  = 2'd3
	} punct_t;

	// Appends one token to the slot list of the current word.
	function automatic slots_t push_tok(slots_t s, kind_t k, logic [15:0] ln,
	                                    logic [11:0] cl, logic [11:0] lg);
		tok_t t;
		t.kind = k;
		t.line = ln;
		t.col  = cl;
		t.len  = lg;
		t.last = 1'b0;
		if (s.n == 2'd0) begin
			s.t0 = t;
			s.n  = 2'd1;
		end else if (s.n == 2'd1) begin
			s.t1 = t;
			s.n  = 2'd2;
		end
		return s;
	endfunction

	function automatic logic [1:0] ptr_inc(logic [1:0] p);
		return (p == 2'd2) ? 2'd0 : p + 2'd1;
	endfunction

	// Input register.
	logic        in_valid_s1;
	logic [1:0]  op_s1;
	logic [15:0] code_s1;

	// Scanner state.
	mode_t       mode_q, mode_d;
	punct_t      punct_q, punct_d;
	logic [15:0] line_q, line_d;
	logic [11:0] col_q, col_d;
	logic        wact_q, wact_d;
	logic [11:0] wstart_q, wstart_d;
	logic [11:0] wlen_q, wlen_d;
	logic [34:0] wpfx_q, wpfx_d;
	logic        ewait_q, ewait_d;
	logic [11:0] ecol_q, ecol_d;

	// Output queue.
	tok_t        q_mem [3];
	logic [1:0]  wr_q, rd_q, cnt_q;

	logic        proc_fire, pop;
	slots_t      slots, fin_slots;
	logic        fin_ewait;
	logic [11:0] fin_ecol;

	logic        kw_hit;
	kind_t       kw_kind;
	logic        wc, sp;
	logic [6:0]  up7;
	logic [11:0] col_adv, comb_len;
	logic        combo;

	// Items enter the scanner only while the queue has room for two tokens.
	assign proc_fire = in_valid_s1 && (cnt_q <= 2'd1);
	assign s_tready  = !in_valid_s1 || proc_fire;
	assign pop       = m_tvalid && m_tready;

	always_comb begin
		wc = ((code_s1 >= 16'h0041) && (code_s1 <= 16'h005A)) ||
		     ((code_s1 >= 16'h0061) && (code_s1 <= 16'h007A)) ||
		     ((code_s1 >= 16'h0030) && (code_s1 <= 16'h0039)) ||
		     (code_s1 == CH_UNDER) || (code_s1 == CH_DOLLAR) || (code_s1 == CH_HASH);
		sp = ((code_s1 >= 16'd9) && (code_s1 <= 16'd13)) || (code_s1 == CH_SPACE);
		if ((code_s1 >= 16'h0061) && (code_s1 <= 16'h007A)) begin
			up7 = 7'(code_s1 - 16'd32);
		end else begin
			up7 = code_s1[6:0];
		end
		col_adv = (col_q < COL_CAP) ? col_q + 12'd1 : col_q;
	end

	// Keyword match on the word collected so far.
	always_comb begin
		kw_hit  = 1'b1;
		kw_kind = K_IF;
		if (wlen_q == 12'd2 && wpfx_q == P_IF) begin
			kw_kind = K_IF;
		end else if (wlen_q == 12'd4 && wpfx_q == P_THEN) begin
			kw_kind = K_THEN;
		end else if (wlen_q == 12'd5 && wpfx_q == P_ELSIF) begin
			kw_kind = K_ELSIF;
		end else if (wlen_q == 12'd4 && wpfx_q == P_ELSE) begin
			kw_kind = K_ELSE;
		end else if (wlen_q == 12'd3 && wpfx_q == P_FOR) begin
			kw_kind = K_FOR;
		end else if (wlen_q == 12'd5 && wpfx_q == P_WHILE) begin
			kw_kind = K_WHILE;
		end else if (wlen_q == 12'd4 && wpfx_q == P_LOOP) begin
			kw_kind = K_LOOP;
		end else if (wlen_q == 12'd5 && wpfx_q == P_BEGIN) begin
			kw_kind = K_BEGIN;
		end else if (wlen_q == 12'd3 && wpfx_q == P_END) begin
			kw_kind = K_END;
		end else if (wlen_q == 12'd4 && wpfx_q == P_CASE) begin
			kw_kind = K_CASE;
		end else begin
			kw_hit = 1'b0;
		end
	end

	// Closing the current word. The word always ends at the current column, and
	// nothing has been emitted yet for this item when it happens.
	always_comb begin
		fin_slots = '0;
		fin_ewait = ewait_q;
		fin_ecol  = ecol_q;
		combo     = kw_hit && (kw_kind == K_IF || kw_kind == K_LOOP || kw_kind == K_CASE);
		comb_len  = (col_q >= ecol_q) ? col_q - ecol_q : 12'd0;
		if (ewait_q && combo) begin
			fin_ewait = 1'b0;
			unique case (kw_kind)
				K_IF:    fin_slots = push_tok(fin_slots, K_END_IF, line_q, ecol_q, comb_len);
				K_LOOP:  fin_slots = push_tok(fin_slots, K_END_LOOP, line_q, ecol_q, comb_len);
				default: fin_slots = push_tok(fin_slots, K_END_CASE, line_q, ecol_q, comb_len);
			endcase
		end else begin
			if (ewait_q) begin
				fin_ewait = 1'b0;
				fin_slots = push_tok(fin_slots, K_END, line_q, ecol_q, 12'd3);
			end
			if (kw_hit && kw_kind == K_END) begin
				fin_ewait = 1'b1;
				fin_ecol  = wstart_q;
			end else if (kw_hit) begin
				fin_slots = push_tok(fin_slots, kw_kind, line_q, wstart_q, wlen_q);
			end
		end
	end

	// Next scanner state and the tokens of the item in the input register.
	always_comb begin
		mode_d   = mode_q;
		punct_d  = punct_q;
		line_d   = line_q;
		col_d    = col_q;
		wact_d   = wact_q;
		wstart_d = wstart_q;
		wlen_d   = wlen_q;
		wpfx_d   = wpfx_q;
		ewait_d  = ewait_q;
		ecol_d   = ecol_q;
		slots    = '0;
		case (op_s1)
			OP_CHAR: begin
				col_d = col_adv;
				if (mode_q == M_BLOCK) begin
					if (punct_q == P_STAR && code_s1 == CH_SLASH) begin
						mode_d  = M_NORMAL;
						punct_d = P_NONE;
					end else begin
						punct_d = (code_s1 == CH_STAR) ? P_STAR : P_NONE;
					end
				end else if (mode_q == M_LINE) begin
					mode_d = M_LINE;
				end else if (mode_q == M_STRING) begin
					if (code_s1 == CH_QUOTE) begin
						mode_d = M_QUOTE;
					end
				end else if (mode_q == M_QUOTE && code_s1 == CH_QUOTE) begin
					mode_d = M_STRING;
				end else begin
					mode_d = M_NORMAL;
					if (wact_q && wc) begin
						for (int i = 0; i < 5; i++) begin
							if (wlen_q == 12'(i)) begin
								wpfx_d[7*i +: 7] = up7;
							end
						end
						if (wlen_q < LEN_CAP) begin
							wlen_d = wlen_q + 12'd1;
						end
					end else begin
						if (wact_q) begin
							slots   = fin_slots;
							ewait_d = fin_ewait;
							ecol_d  = fin_ecol;
							wact_d  = 1'b0;
						end
						if (ewait_d && !wc && !sp) begin
							ewait_d = 1'b0;
							slots   = push_tok(slots, K_END, line_q, ecol_d, 12'd3);
						end
						if (punct_q == P_SLASH && code_s1 == CH_STAR) begin
							mode_d  = M_BLOCK;
							punct_d = P_NONE;
						end else if (punct_q == P_DASH && code_s1 == CH_DASH) begin
							mode_d  = M_LINE;
							punct_d = P_NONE;
						end else begin
							punct_d = P_NONE;
							if (code_s1 == CH_SLASH) begin
								punct_d = P_SLASH;
							end else if (code_s1 == CH_DASH) begin
								punct_d = P_DASH;
							end else if (code_s1 == CH_QUOTE) begin
								mode_d = M_STRING;
							end else if (wc) begin
								wact_d   = 1'b1;
								wstart_d = col_q;
								wlen_d   = 12'd1;
								wpfx_d   = 35'(up7);
							end
						end
					end
				end
			end
			OP_EOL: begin
				if (mode_q == M_NORMAL) begin
					if (wact_q) begin
						slots   = fin_slots;
						ewait_d = fin_ewait;
						ecol_d  = fin_ecol;
					end
					if (ewait_d) begin
						slots = push_tok(slots, K_END, line_q, ecol_d, 12'd3);
					end
				end else if (mode_q != M_BLOCK) begin
					mode_d = M_NORMAL;
				end
				wact_d  = 1'b0;
				ewait_d = 1'b0;
				punct_d = P_NONE;
				line_d  = (line_q < LINE_CAP) ? line_q + 16'd1 : line_q;
				col_d   = '0;
			end
			OP_RESTART: begin
				mode_d   = M_NORMAL;
				punct_d  = P_NONE;
				line_d   = '0;
				col_d    = '0;
				wact_d   = 1'b0;
				wstart_d = '0;
				wlen_d   = '0;
				wpfx_d   = '0;
				ewait_d  = 1'b0;
				ecol_d   = '0;
			end
			default: begin
				mode_d = mode_q;
			end
		endcase
		if (slots.n == 2'd1) begin
			slots.t0.last = 1'b1;
		end else if (slots.n == 2'd2) begin
			slots.t1.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			mode_q      <= M_NORMAL;
			punct_q     <= P_NONE;
			line_q      <= '0;
			col_q       <= '0;
			wact_q      <= 1'b0;
			wstart_q    <= '0;
			wlen_q      <= '0;
			wpfx_q      <= '0;
			ewait_q     <= 1'b0;
			ecol_q      <= '0;
			wr_q        <= '0;
			rd_q        <= '0;
			cnt_q       <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				in_valid_s1 <= 1'b1;
			end else if (proc_fire) begin
				in_valid_s1 <= 1'b0;
			end
			if (proc_fire) begin
				mode_q   <= mode_d;
				punct_q  <= punct_d;
				line_q   <= line_d;
				col_q    <= col_d;
				wact_q   <= wact_d;
				wstart_q <= wstart_d;
				wlen_q   <= wlen_d;
				wpfx_q   <= wpfx_d;
				ewait_q  <= ewait_d;
				ecol_q   <= ecol_d;
				if (slots.n == 2'd1) begin
					wr_q <= ptr_inc(wr_q);
				end else if (slots.n == 2'd2) begin
					wr_q <= ptr_inc(ptr_inc(wr_q));
				end
			end
			if (pop) begin
				rd_q <= ptr_inc(rd_q);
			end
			cnt_q <= cnt_q + (proc_fire ? slots.n : 2'd0) - {1'b0, pop};
		end
	end

	// Input register and queue payloads, no reset needed.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			code_s1 <= s_tdata;
		end
		if (proc_fire && slots.n != 2'd0) begin
			q_mem[wr_q] <= slots.t0;
			if (slots.n == 2'd2) begin
				q_mem[ptr_inc(wr_q)] <= slots.t1;
			end
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {q_mem[rd_q].len, q_mem[rd_q].col, q_mem[rd_q].line};
	assign m_tuser  = q_mem[rd_q].kind;
	assign m_tlast  = q_mem[rd_q].last;

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for block_keyword_lexer_core. A queue of text words
// (characters, line ends, restarts) feeds a clocked driver; a clocked monitor
// takes tokens with random back-pressure and compares each one, field by
// field, with the tokens that an in-bench lexer model predicted when the
// causing word was accepted.
// ----------------------------------------------------------------------------

module tb;
	import bkl_pkg::*;

	localparam int          CYCLE_LIMIT  = 800000;
	localparam int          RANDOM_WORDS = 450;
	localparam int          TAIL_CYCLES  = 20;
	// The operation code that the block has no use for; it must do nothing.
	localparam logic [1:0]  OP_UNUSED    = 2'd3;

	// Scanner modes and remembered punctuation of the lexer model.
	typedef enum logic [2:0] {
		SC_CODE,
		SC_BLOCK,
		SC_LINE,
		SC_STRING,
		SC_QUOTE
	} scan_t;

	typedef enum logic [1:0] {
		PU_NONE,
		PU_SLASH,
		PU_DASH,
		PU_STAR
	} punct_t;

	// One word of source text waiting to be driven. A word marked nogap is
	// sent without any idle cycle in front of it.
	typedef struct {
		logic [1:0]  op;
		logic [15:0] code;
		bit          nogap;
	} feed_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'h0000;
	logic [1:0]  s_tuser = OP_CHAR;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;

	feed_item_t  text_feed[$];
	tok_t        pending_tokens[$];
	tok_t        step_toks[$];

	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          send_gap = 0;
	int          take_stall = 0;
	bit          calm_in = 1'b0;
	bit          calm_out = 1'b0;

	string kw_names[10] = '{"if", "then", "elsif", "else", "for", "while", "loop",
		"begin", "end", "case"};
	string word_alphabet =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_$#";
	string punct_chars = "();,.+*/-=<>";

	// Lexer model state.
	scan_t       mode;
	punct_t      punct;
	logic [15:0] cur_line;
	logic [11:0] cur_col;
	bit          in_word;
	logic [11:0] wstart;
	logic [11:0] wlen;
	logic [34:0] wspell;
	bit          end_open;
	logic [11:0] end_col;

	block_keyword_lexer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Lexer model
	// ------------------------------------------------------------------------

	// Only ASCII letters, digits, underscore, dollar and hash build words.
	function automatic bit word_char(logic [15:0] c);
		return (c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A) ||
			(c >= 16'h0030 && c <= 16'h0039) || c == CH_UNDER || c == CH_DOLLAR ||
			c == CH_HASH;
	endfunction

	// Tab through carriage return and space may sit between END and its partner.
	function automatic bit blank(logic [15:0] c);
		return (c >= 16'd9 && c <= 16'd13) || c == CH_SPACE;
	endfunction

	function automatic logic [6:0] upcase7(logic [15:0] c);
		if (c >= 16'h0061 && c <= 16'h007A) begin
			c = c - 16'd32;
		end
		return c[6:0];
	endfunction

	function automatic void bump_col();
		if (cur_col < COL_CAP) begin
			cur_col++;
		end
	endfunction

	// A word's length and its first five upper-cased characters decide whether
	// it is a keyword.
	function automatic bit keyword_of(output kind_t k);
		bit hit;
		hit = 1'b1;
		k = K_IF;
		case (wlen)
			12'd2: begin
				if (wspell != P_IF) hit = 1'b0;
			end
			12'd3: begin
				if (wspell == P_FOR) k = K_FOR;
				else if (wspell == P_END) k = K_END;
				else hit = 1'b0;
			end
			12'd4: begin
				if (wspell == P_THEN) k = K_THEN;
				else if (wspell == P_ELSE) k = K_ELSE;
				else if (wspell == P_LOOP) k = K_LOOP;
				else if (wspell == P_CASE) k = K_CASE;
				else hit = 1'b0;
			end
			12'd5: begin
				if (wspell == P_ELSIF) k = K_ELSIF;
				else if (wspell == P_WHILE) k = K_WHILE;
				else if (wspell == P_BEGIN) k = K_BEGIN;
				else hit = 1'b0;
			end
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// At most two tokens come out of one input word.
	function automatic void put_token(kind_t k, logic [11:0] at, logic [11:0] n);
		tok_t t;
		if (step_toks.size() >= 2) begin
			return;
		end
		t.kind = k;
		t.line = cur_line;
		t.col  = at;
		t.len  = n;
		t.last = 1'b0;
		step_toks.insert(step_toks.size(), t);
	endfunction

	task automatic lex_close_word(input logic [11:0] stop_col);
		kind_t k;
		kind_t joined;
		bit    hit;
		hit = keyword_of(k);
		in_word = 1'b0;
		if (end_open) begin
			end_open = 1'b0;
			if (hit && (k == K_IF || k == K_LOOP || k == K_CASE)) begin
				if (k == K_IF) joined = K_END_IF;
				else if (k == K_LOOP) joined = K_END_LOOP;
				else joined = K_END_CASE;
				// Length runs from END to the end of the partner word, gap included.
				put_token(joined, end_col, (stop_col >= end_col) ? stop_col - end_col : 12'd0);
				return;
			end
			put_token(K_END, end_col, 12'd3);
		end
		if (hit && k == K_END) begin
			end_open = 1'b1;
			end_col = wstart;
		end else if (hit) begin
			put_token(k, wstart, wlen);
		end
	endtask

	task automatic lex_char(input logic [15:0] c);
		logic [11:0] at;
		at = cur_col;
		if (mode == SC_BLOCK) begin
			if (punct == PU_STAR && c == CH_SLASH) begin
				mode = SC_CODE;
				punct = PU_NONE;
			end else if (c == CH_STAR) begin
				punct = PU_STAR;
			end else begin
				punct = PU_NONE;
			end
			bump_col();
			return;
		end
		if (mode == SC_LINE) begin
			bump_col();
			return;
		end
		if (mode == SC_STRING) begin
			if (c == CH_QUOTE) mode = SC_QUOTE;
			bump_col();
			return;
		end
		if (mode == SC_QUOTE) begin
			// A second quote right after one is an escaped quote inside the string.
			if (c == CH_QUOTE) begin
				mode = SC_STRING;
				bump_col();
				return;
			end
			mode = SC_CODE;
		end
		if (in_word) begin
			if (word_char(c)) begin
				if (wlen < 12'd5) wspell[int'(wlen) * 7 +: 7] = upcase7(c);
				if (wlen < LEN_CAP) wlen++;
				bump_col();
				return;
			end
			lex_close_word(at);
		end
		if (end_open && !word_char(c) && !blank(c)) begin
			end_open = 1'b0;
			put_token(K_END, end_col, 12'd3);
		end
		if (punct == PU_SLASH && c == CH_STAR) begin
			mode = SC_BLOCK;
			punct = PU_NONE;
			bump_col();
			return;
		end
		if (punct == PU_DASH && c == CH_DASH) begin
			mode = SC_LINE;
			punct = PU_NONE;
			bump_col();
			return;
		end
		punct = PU_NONE;
		if (c == CH_SLASH) begin
			punct = PU_SLASH;
		end else if (c == CH_DASH) begin
			punct = PU_DASH;
		end else if (c == CH_QUOTE) begin
			mode = SC_STRING;
		end else if (word_char(c)) begin
			in_word = 1'b1;
			wstart = at;
			wlen = 12'd1;
			wspell = '0;
			wspell[6:0] = upcase7(c);
		end
		bump_col();
	endtask

	task automatic lex_line_end();
		if (mode == SC_CODE) begin
			if (in_word) lex_close_word(cur_col);
			if (end_open) begin
				end_open = 1'b0;
				put_token(K_END, end_col, 12'd3);
			end
		end else if (mode != SC_BLOCK) begin
			// Strings and line comments stop here; block comments carry on.
			mode = SC_CODE;
		end
		in_word = 1'b0;
		end_open = 1'b0;
		punct = PU_NONE;
		if (cur_line < LINE_CAP) cur_line++;
		cur_col = '0;
	endtask

	task automatic lex_clear();
		mode = SC_CODE;
		punct = PU_NONE;
		cur_line = '0;
		cur_col = '0;
		in_word = 1'b0;
		wstart = '0;
		wlen = '0;
		wspell = '0;
		end_open = 1'b0;
		end_col = '0;
	endtask

	// Runs one accepted input word through the model and queues its tokens,
	// the final one marked as last.
	task automatic lex_step(input logic [1:0] op, input logic [15:0] c);
		tok_t t;
		step_toks.delete();
		case (op)
			OP_CHAR:    lex_char(c);
			OP_EOL:     lex_line_end();
			OP_RESTART: lex_clear();
			default: ;
		endcase
		if (step_toks.size() > 0) begin
			t = step_toks[step_toks.size() - 1];
			t.last = 1'b1;
			step_toks[step_toks.size() - 1] = t;
		end
		foreach (step_toks[i]) pending_tokens.insert(pending_tokens.size(), step_toks[i]);
	endtask

	// ------------------------------------------------------------------------
	// Text generation
	// ------------------------------------------------------------------------

	task automatic push_item(input logic [1:0] op, input logic [15:0] c, input bit nogap);
		feed_item_t it;
		it.op = op;
		it.code = c;
		it.nogap = nogap;
		text_feed.insert(text_feed.size(), it);
	endtask

	task automatic push_char(input logic [15:0] c);
		push_item(OP_CHAR, c, 1'b0);
	endtask

	task automatic push_eol();
		// The code unit is ignored on a line end, so it carries random bits.
		push_item(OP_EOL, 16'($urandom), 1'b0);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_char(16'(s[i]));
	endtask

	// Same text with every letter in a random case.
	task automatic push_mixed(input string s);
		logic [15:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = 16'(s[i]);
			if (((c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A)) &&
				$urandom_range(0, 1) == 1) begin
				c = c ^ 16'h0020;
			end
			push_char(c);
		end
	endtask

	task automatic push_blank();
		int pick;
		pick = $urandom_range(0, 7);
		push_char(pick >= 5 ? CH_SPACE : 16'(9 + pick));
	endtask

	task automatic push_ident();
		int n;
		if ($urandom_range(0, 1) == 0) begin
			n = $urandom_range(1, 7);
			repeat (n) push_char(16'(word_alphabet[$urandom_range(0, word_alphabet.len() - 1)]));
		end else if ($urandom_range(0, 1) == 0) begin
			// A keyword with a tail is just a word.
			push_mixed(kw_names[$urandom_range(0, 9)]);
			push_char(16'(word_alphabet[$urandom_range(0, word_alphabet.len() - 1)]));
		end else begin
			push_char($urandom_range(0, 1) ? CH_DOLLAR : CH_HASH);
			push_mixed(kw_names[$urandom_range(0, 9)]);
		end
	endtask

	// One random stretch of source text; keywords and END pairs take 44 of every
	// 100 picks, the rest identifiers, punctuation, comments, strings and noise.
	task automatic add_fragment();
		int pick;
		int n;
		string tails[3] = '{"if", "loop", "case"};
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			push_mixed(kw_names[$urandom_range(0, 9)]);
		end else if (pick < 44) begin
			push_mixed("end");
			n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
			repeat (n) push_blank();
			case ($urandom_range(0, 9))
				0, 1:    push_mixed(kw_names[$urandom_range(0, 9)]);
				2:       push_ident();
				3:       push_eol();
				default: push_mixed(tails[$urandom_range(0, 2)]);
			endcase
		end else if (pick < 52) begin
			push_ident();
		end else if (pick < 60) begin
			push_char(16'(punct_chars[$urandom_range(0, punct_chars.len() - 1)]));
		end else if (pick < 66) begin
			push_text("/*");
			n = $urandom_range(0, 6);
			repeat (n) begin
				case ($urandom_range(0, 5))
					0: push_mixed(kw_names[$urandom_range(0, 9)]);
					1: push_char(CH_STAR);
					2: push_char(CH_SLASH);
					3: push_eol();
					4: push_char(CH_QUOTE);
					default: push_blank();
				endcase
			end
			if ($urandom_range(0, 6) != 0) push_text("*/");
		end else if (pick < 71) begin
			push_text("--");
			if ($urandom_range(0, 1)) push_mixed(kw_names[$urandom_range(0, 9)]);
			push_blank();
			if ($urandom_range(0, 3) != 0) push_eol();
		end else if (pick < 77) begin
			push_char(CH_QUOTE);
			n = $urandom_range(0, 4);
			repeat (n) begin
				case ($urandom_range(0, 3))
					0: push_text("''");
					1: push_mixed(kw_names[$urandom_range(0, 9)]);
					default: push_blank();
				endcase
			end
			if ($urandom_range(0, 4) != 0) push_char(CH_QUOTE);
			else push_eol();
		end else if (pick < 87) begin
			push_eol();
		end else if (pick < 95) begin
			case ($urandom_range(0, 2))
				0: push_char(16'($urandom_range(0, 65535)));
				1: push_char(16'($urandom_range(128, 255)));
				default: push_char(16'($urandom_range(0, 127)));
			endcase
		end else if (pick < 98) begin
			n = $urandom_range(1, 3);
			repeat (n) push_blank();
		end else begin
			push_item($urandom_range(0, 1) ? OP_RESTART : OP_UNUSED, 16'($urandom), 1'b0);
		end
		if ($urandom_range(0, 9) < 6) push_blank();
	endtask

	// ------------------------------------------------------------------------
	// Driver: presents queued words, with a random idle gap before each one
	// and calm stretches without gaps. Prediction happens on acceptance.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		feed_item_t it;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				lex_step(s_tuser, s_tdata);
				if ($urandom_range(0, 63) == 0) calm_in = !calm_in;
				if (text_feed.size() > 0 && !text_feed[0].nogap && !calm_in) begin
					send_gap = $urandom_range(0, 9);
				end else begin
					send_gap = 0;
				end
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (text_feed.size() > 0) begin
					it = text_feed.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= it.code;
					s_tuser <= it.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: takes tokens with a random stall after each one and checks
	// them against the oldest predicted token.
	// ------------------------------------------------------------------------
	task automatic check_token();
		tok_t want;
		if (pending_tokens.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("unexpected token: kind %0d line %0d col %0d len %0d last %0b",
					m_tuser, m_tdata[15:0], m_tdata[27:16], m_tdata[39:28], m_tlast);
			end
		end else begin
			want = pending_tokens.pop_front();
			if (m_tuser !== want.kind || m_tdata[15:0] !== want.line ||
				m_tdata[27:16] !== want.col || m_tdata[39:28] !== want.len ||
				m_tlast !== want.last) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("token mismatch: expected kind %0d line %0d col %0d len %0d last %0b",
						want.kind, want.line, want.col, want.len, want.last);
					$display("                got      kind %0d line %0d col %0d len %0d last %0b",
						m_tuser, m_tdata[15:0], m_tdata[27:16], m_tdata[39:28], m_tlast);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				check_token();
				if ($urandom_range(0, 31) == 0) calm_out = !calm_out;
				take_stall = calm_out ? 0 : $urandom_range(0, 9);
			end
			if (take_stall > 0) begin
				take_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// A run that stops making progress ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		int goal;
		lex_clear();

		// Directed text: the unused operation, a mixed-case END with a tab before
		// IF, a string with an escaped quote, a line comment, a block comment over
		// a line end, END ended by a non-ASCII unit, and a restart.
		push_item(OP_UNUSED, 16'hFFFF, 1'b0);
		push_text("eNd\tIf'a''b'--c");
		push_eol();
		push_text("/*");
		push_eol();
		push_text("*/END");
		push_char(16'hFFFF);
		push_item(OP_RESTART, 16'h0000, 1'b0);
		push_text("If");
		push_eol();

		// Random source text.
		goal = text_feed.size() + RANDOM_WORDS;
		while (text_feed.size() < goal) add_fragment();

		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (text_feed.size() != 0 || s_tvalid || pending_tokens.size() != 0) begin
			@(posedge clk);
		end
		// Give a stray extra token time to show up.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### sim.f
src/bkl_pkg.sv
src/block_keyword_lexer_core.sv
tb/sv/tb.sv
